@@ rtl/core/bpr_pkg.sv @@
`timescale 1ns / 1ps

package bpr_pkg;

  // Field widths of the stream payloads.
  localparam int KIND_W      = 2;
  localparam int FW_W        = 6;
  localparam int VAL_W       = 32;
  localparam int K_W         = 5;
  localparam int VB_W        = 3;
  localparam int CAP_W       = 24;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  // Default limit on the length of one unary run.
  localparam int DEFAULT_MAX_UNARY = 1024;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RICE     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH    = 2'd3;

  // Datapath operations, one per cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIELD,
    OP_CHUNK,
    OP_END,
    OP_REM,
    OP_FLUSH,
    OP_OVER,
    OP_STATUS
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_REM,
    S_STATUS
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              over;
    logic              q_gt31;
    logic              k_nz;
    logic              out_free;
  } stat_t;

endpackage

@@ rtl/core/bitstream_packer_rice_encoder_top.sv @@
// A result appears in the output register the cycle after its step; one step a cycle while the
// output register is free. Steps run through the single bit writer. Field and flush items take
// a write step and a status step; a Rice item takes one step per 31-bit zero chunk of its unary
// run, an end step, a remainder step if it has remainder bits, and a status step.
// Reset (rst, synchronous, active high) empties the packer, clears the flag and byte count
// and sets the capacity to its largest value.
`timescale 1ns / 1ps

module bitstream_packer_rice_encoder_top
  import bpr_pkg::*;
#(
  parameter int MAX_UNARY = DEFAULT_MAX_UNARY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // field_width[5:0], value[37:6], rice_k[42:38], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // word[31:0], valid_bytes[34:32], out_of_space[35], bytes_used[59:36], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // The capacity register takes a write in any cycle outside reset.
  assign cfg_ready = !rst;

  // Sequencer for the steps of each item.
  bpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Bit writer, flush logic and output register.
  bpr_dpath #(
    .MAX_UNARY (MAX_UNARY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cfg_data  (cfg_data),
    .cfg_we    (cfg_valid),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

@@ rtl/core/bpr_ctrl.sv @@
`timescale 1ns / 1ps

module bpr_ctrl
  import bpr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. Every step waits until the output register is free.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.out_free) begin
          case (stat.kind)
            KIND_UNSIGNED, KIND_SIGNED: begin
              cmd.op     = OP_FIELD;
              state_next = S_STATUS;
            end
            KIND_RICE: begin
              if (stat.over) begin
                cmd.op     = OP_OVER;
                state_next = S_STATUS;
              end else if (stat.q_gt31) begin
                cmd.op = OP_CHUNK;
              end else begin
                cmd.op     = OP_END;
                state_next = stat.k_nz ? S_REM : S_STATUS;
              end
            end
            default: begin
              cmd.op     = OP_FLUSH;
              state_next = S_STATUS;
            end
          endcase
        end
      end
      S_REM: begin
        if (stat.out_free) begin
          cmd.op     = OP_REM;
          state_next = S_STATUS;
        end
      end
      S_STATUS: begin
        // The status result goes out while the next item is taken in.
        if (stat.out_free) begin
          cmd.op     = OP_STATUS;
          in_ready   = 1'b1;
          cmd.load   = in_valid;
          state_next = in_valid ? S_RUN : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Nothing is taken in while reset is held.
    if (rst) begin
      in_ready = 1'b0;
      cmd.load = 1'b0;
    end
  end

endmodule

@@ rtl/core/bpr_dpath.sv @@
`timescale 1ns / 1ps

module bpr_dpath
  import bpr_pkg::*;
#(
  parameter int MAX_UNARY = DEFAULT_MAX_UNARY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic [CAP_W-1:0]       cfg_data,
  input  logic                   cfg_we,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_last
);

  localparam int QW = $clog2(MAX_UNARY + 1);

  // Left shift where a shift of 32 or more gives zero.
  function automatic logic [31:0] shl32(input logic [31:0] x, input logic [5:0] s);
    shl32 = (s >= 6'd32) ? 32'd0 : (x << s[4:0]);
  endfunction

  // Mask of the low w bits, w up to 32.
  function automatic logic [31:0] low_mask(input logic [5:0] w);
    low_mask = (w >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << w[4:0]) - 32'd1);
  endfunction

  // Packer state.
  logic [31:0]      pend, pend_next;
  logic [5:0]       free, free_next;
  logic [CAP_W-1:0] emitted, emitted_next;
  logic             exh, exh_next;
  logic [CAP_W-1:0] capacity;

  // Current item.
  logic [KIND_W-1:0] kind_r;
  logic [FW_W-1:0]   fw_r;
  logic [VAL_W-1:0]  value_r;
  logic [K_W-1:0]    k_r;
  logic [31:0]       u_r;
  logic [QW-1:0]     q_r;
  logic              over_r;

  // Input decode.
  logic [FW_W-1:0]  in_fw, in_fw_clamped;
  logic [VAL_W-1:0] in_value;
  logic [K_W-1:0]   in_k;
  logic [31:0]      in_u, in_quot;

  assign in_fw         = in_data[5:0];
  assign in_value      = in_data[37:6];
  assign in_k          = in_data[42:38];
  assign in_fw_clamped = (in_fw > 6'd32) ? 6'd32 : in_fw;
  assign in_u          = {in_value[30:0], 1'b0} ^ {32{in_value[31]}};
  assign in_quot       = in_u >> in_k;

  // Item registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      fw_r    <= in_fw_clamped;
      value_r <= in_value;
      k_r     <= in_k;
      u_r     <= in_u;
      over_r  <= (in_quot >= 32'(MAX_UNARY));
      q_r     <= in_quot[QW-1:0] + QW'(1);
    end else if (cmd.op == OP_CHUNK) begin
      q_r <= q_r - QW'(31);
    end
  end

  // Field selection for the bit writer.
  logic [5:0]  put_n;
  logic [31:0] put_val;

  always_comb begin
    case (cmd.op)
      OP_FIELD: begin
        put_n   = fw_r;
        put_val = value_r & low_mask(fw_r);
      end
      OP_CHUNK: begin
        put_n   = 6'd31;
        put_val = 32'd0;
      end
      OP_END: begin
        put_n   = {1'b0, q_r[4:0]};
        put_val = 32'd1;
      end
      OP_REM: begin
        put_n   = {1'b0, k_r};
        put_val = u_r & low_mask({1'b0, k_r});
      end
      default: begin
        put_n   = 6'd0;
        put_val = 32'd0;
      end
    endcase
  end

  // Space check and the two write paths.
  logic             space_ok, fits;
  logic [5:0]       spill;
  logic [6:0]       free_wrap;
  logic [31:0]      full_word;

  assign space_ok  = !exh && ({1'b0, emitted} + 25'd4 <= {1'b0, capacity});
  assign fits      = put_n < free;
  assign spill     = put_n - free;
  assign free_wrap = {1'b0, free} + 7'd32 - {1'b0, put_n};
  assign full_word = shl32(pend, free) | (put_val >> spill[4:0]);

  // Flush: whole bytes of the pending bits, as far as capacity allows.
  logic [5:0]       fill, fill_up;
  logic [2:0]       need, avail, cnt;
  logic [CAP_W-1:0] room;
  logic [31:0]      flush_src, byte_mask;

  assign fill      = 6'd32 - free;
  assign fill_up   = fill + 6'd7;
  assign need      = fill_up[5:3];
  assign room      = (capacity > emitted) ? (capacity - emitted) : '0;
  assign avail     = (room >= CAP_W'(4)) ? 3'd4 : room[2:0];
  assign cnt       = exh ? 3'd0 : ((need <= avail) ? need : avail);
  assign flush_src = shl32(pend, free);

  always_comb begin
    case (cnt)
      3'd1:    byte_mask = 32'hFF00_0000;
      3'd2:    byte_mask = 32'hFFFF_0000;
      3'd3:    byte_mask = 32'hFFFF_FF00;
      3'd4:    byte_mask = 32'hFFFF_FFFF;
      default: byte_mask = 32'h0000_0000;
    endcase
  end

  // Next packer state and the result that this step produces.
  logic            emit;
  logic [31:0]     emit_word;
  logic [VB_W-1:0] emit_vb;
  logic            emit_last;

  always_comb begin
    pend_next    = pend;
    free_next    = free;
    emitted_next = emitted;
    exh_next     = exh;
    emit         = 1'b0;
    emit_word    = 32'd0;
    emit_vb      = 3'd0;
    emit_last    = 1'b0;
    case (cmd.op)
      OP_FIELD, OP_CHUNK, OP_END, OP_REM: begin
        if (!space_ok) begin
          exh_next = 1'b1;
        end else if (fits) begin
          pend_next = shl32(pend, put_n) | put_val;
          free_next = free - put_n;
        end else begin
          pend_next    = put_val;
          free_next    = free_wrap[5:0];
          emitted_next = emitted + CAP_W'(4);
          emit         = 1'b1;
          emit_word    = full_word;
          emit_vb      = 3'd4;
        end
      end
      OP_FLUSH: begin
        pend_next    = 32'd0;
        free_next    = 6'd32;
        emitted_next = emitted + CAP_W'(cnt);
        exh_next     = exh || (need > avail);
        emit         = (cnt != 3'd0);
        emit_word    = flush_src & byte_mask;
        emit_vb      = cnt;
      end
      OP_OVER: begin
        exh_next = 1'b1;
      end
      OP_STATUS: begin
        emit      = 1'b1;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Byte count as it stands after this step.
  logic [5:0]       fill_next, fill_next_up;
  logic [CAP_W-1:0] used_next;

  assign fill_next    = 6'd32 - free_next;
  assign fill_next_up = fill_next + 6'd7;
  assign used_next    = emitted_next + CAP_W'(fill_next_up[5:3]);

  // Packer state and capacity registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 32'd0;
      free     <= 6'd32;
      emitted  <= '0;
      exh      <= 1'b0;
      capacity <= '1;
    end else begin
      pend    <= pend_next;
      free    <= free_next;
      emitted <= emitted_next;
      exh     <= exh_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= {4'd0, used_next, exh_next, emit_vb, emit_word};
      out_last <= emit_last;
    end
  end

  // Status toward the controller.
  assign stat.kind     = kind_r;
  assign stat.over     = over_r;
  assign stat.q_gt31   = (q_r > QW'(31));
  assign stat.k_nz     = (k_r != '0);
  assign stat.out_free = !out_valid || out_ready;

endmodule
